// ===== rtl/core/trtcm_pkg.sv =====
package trtcm_pkg;

   localparam int TIME_BITS_DEFAULT = 48;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int ARRIVAL_BITS = 48;
   localparam int RATE_BITS    = 32;
   localparam int RATE_FRAC    = 16;
   localparam int BURST_BITS   = 24;
   localparam int BYTES_BITS   = 16;

   // refill product in 2^-16 byte units, saturated; all ones exceeds any bucket
   localparam int SAT_BITS = BURST_BITS + RATE_FRAC + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMMITTED_RATE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PEAK_RATE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMMITTED_BURST = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PEAK_BURST      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PACKET_BYTES    = 3'd4;

   localparam logic [BYTES_BITS-1:0] PACKET_BYTES_RESET = 16'd1000;

   typedef logic [1:0] color_type;

   localparam color_type COLOR_GREEN  = 2'd0;
   localparam color_type COLOR_YELLOW = 2'd1;
   localparam color_type COLOR_RED    = 2'd2;

   // bucket reload on a burst register write
   typedef struct packed {
      logic                  committed;
      logic                  peak;
      logic [BURST_BITS-1:0] burst;
   } load_type;

endpackage

// ===== rtl/core/trtcm_scale.sv =====
module trtcm_scale #(
   parameter int TIME_BITS = trtcm_pkg::TIME_BITS_DEFAULT,
   parameter int FRAC_BITS = trtcm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            enable,
   input  logic [TIME_BITS-1:0]                            elapsed,
   input  logic [trtcm_pkg::RATE_BITS-1:0]                 rate,
   output logic [trtcm_pkg::BURST_BITS+FRAC_BITS:0]        increment
);
   import trtcm_pkg::*;

   localparam int EXT_BITS     = (TIME_BITS > SAT_BITS ? TIME_BITS : SAT_BITS) + 1;
   localparam int LO_BITS      = RATE_BITS;
   localparam int HI_BITS      = SAT_BITS - LO_BITS;
   localparam int LO_PROD_BITS = LO_BITS + RATE_BITS;
   localparam int HI_PROD_BITS = HI_BITS + RATE_BITS;
   localparam int SUM_BITS     = LO_PROD_BITS + 1;
   localparam int INC_BITS     = BURST_BITS + FRAC_BITS + 1;

   logic [EXT_BITS-1:0]     elapsed_ext;
   logic                    big_in, big_ff;
   logic [LO_PROD_BITS-1:0] lo_prod_in, lo_prod_ff;
   logic [HI_PROD_BITS-1:0] hi_prod_in, hi_prod_ff;
   logic                    hi_over;
   logic [SUM_BITS-1:0]     sum;
   logic                    sum_over;
   logic [SAT_BITS-1:0]     scaled;
   logic [INC_BITS-1:0]     increment_in, increment_ff;

   // split the elapsed time so no product is wider than 32 by 32
   always_comb begin
      elapsed_ext = EXT_BITS'(elapsed);
      big_in      = ((elapsed_ext >> SAT_BITS) != '0) && (rate != '0);
      lo_prod_in  = LO_PROD_BITS'(elapsed_ext[LO_BITS-1:0]) * LO_PROD_BITS'(rate);
      hi_prod_in  = HI_PROD_BITS'(elapsed_ext[SAT_BITS-1:LO_BITS]) * HI_PROD_BITS'(rate);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         big_ff     <= big_in;
         lo_prod_ff <= lo_prod_in;
         hi_prod_ff <= hi_prod_in;
      end
   end

   always_comb begin
      hi_over  = (hi_prod_ff >> HI_BITS) != '0;
      sum      = SUM_BITS'(lo_prod_ff) + (SUM_BITS'(hi_prod_ff[HI_BITS-1:0]) << LO_BITS);
      sum_over = (sum >> SAT_BITS) != '0;
      scaled   = (big_ff || hi_over || sum_over) ? '1 : SAT_BITS'(sum);
   end

   // move from 16 fraction bits to the bucket's fraction bits
   generate
      if (FRAC_BITS >= RATE_FRAC) begin : g_widen
         assign increment_in = INC_BITS'(scaled) << (FRAC_BITS - RATE_FRAC);
      end else begin : g_narrow
         assign increment_in = INC_BITS'(scaled >> (RATE_FRAC - FRAC_BITS));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (enable) begin
         increment_ff <= increment_in;
      end
   end

   assign increment = increment_ff;

endmodule

// ===== rtl/core/trtcm_marker.sv =====
module trtcm_marker #(
   parameter int FRAC_BITS = trtcm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic                                     advanced,
   input  logic [trtcm_pkg::BURST_BITS+FRAC_BITS:0] inc_committed,
   input  logic [trtcm_pkg::BURST_BITS+FRAC_BITS:0] inc_peak,
   input  logic [trtcm_pkg::BURST_BITS-1:0]         committed_burst,
   input  logic [trtcm_pkg::BURST_BITS-1:0]         peak_burst,
   input  logic [trtcm_pkg::BYTES_BITS-1:0]         packet_bytes,
   input  trtcm_pkg::load_type                      load,
   output trtcm_pkg::color_type                     color
);
   import trtcm_pkg::*;

   localparam int TOK_BITS = BURST_BITS + FRAC_BITS;
   localparam int SUM_BITS = TOK_BITS + 2;

   logic [TOK_BITS-1:0] committed_ff, committed_in;
   logic [TOK_BITS-1:0] peak_ff, peak_in;
   logic [TOK_BITS-1:0] cap_committed, cap_peak, need, reload;
   logic [SUM_BITS-1:0] sum_committed, sum_peak;
   logic [TOK_BITS-1:0] fill_committed, fill_peak;
   logic                committed_ok, peak_ok;
   color_type           color_ff, color_in;

   always_comb begin
      cap_committed = TOK_BITS'(committed_burst) << FRAC_BITS;
      cap_peak      = TOK_BITS'(peak_burst) << FRAC_BITS;
      need          = TOK_BITS'(packet_bytes) << FRAC_BITS;
      reload        = TOK_BITS'(load.burst) << FRAC_BITS;

      sum_committed = SUM_BITS'(committed_ff) + SUM_BITS'(inc_committed);
      sum_peak      = SUM_BITS'(peak_ff) + SUM_BITS'(inc_peak);

      // refill clamps at the bucket capacity
      fill_committed = committed_ff;
      fill_peak      = peak_ff;
      if (advanced) begin
         fill_committed = (sum_committed >= SUM_BITS'(cap_committed)) ?
                          cap_committed : TOK_BITS'(sum_committed);
         fill_peak      = (sum_peak >= SUM_BITS'(cap_peak)) ?
                          cap_peak : TOK_BITS'(sum_peak);
      end

      committed_ok = fill_committed >= need;
      peak_ok      = fill_peak >= need;

      committed_in = fill_committed;
      peak_in      = fill_peak;
      if (committed_ok && peak_ok) begin
         committed_in = fill_committed - need;
         peak_in      = fill_peak - need;
         color_in     = COLOR_GREEN;
      end else if (peak_ok) begin
         peak_in      = fill_peak - need;
         color_in     = COLOR_YELLOW;
      end else begin
         color_in     = COLOR_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         peak_ff      <= '0;
      end else begin
         if (load.committed) begin
            committed_ff <= reload;
         end else if (step) begin
            committed_ff <= committed_in;
         end
         if (load.peak) begin
            peak_ff <= reload;
         end else if (step) begin
            peak_ff <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

// ===== rtl/core/two_rate_three_color_marker_core.sv =====
// Two-rate three-color policer (color-blind). Each accepted word is one
// packet arrival time; each result word is its color: green, yellow or red.
// One packet is marked per clock cycle while no result word is stalled, in
// stages from accepted word to result word: input register, elapsed time
// against the last update, 32x32 rate multiply, saturate and scale, then
// the bucket update, whose refill-and-debit of both token registers is not
// pipelined and so sets the rate. A stalled result halts the whole
// pipeline, and req_stall follows rsp_stall while a result is held.
// Rates are Q16.16 bytes per time unit, bursts whole bytes; writing a burst
// register refills that bucket. Write configuration only with the pipeline
// empty.
module two_rate_three_color_marker_core #(
   parameter int TIME_BITS = trtcm_pkg::TIME_BITS_DEFAULT,
   parameter int FRAC_BITS = trtcm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [trtcm_pkg::ARRIVAL_BITS-1:0]   req_arrival_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output trtcm_pkg::color_type                 rsp_color,
   input  logic                                 csr_write,
   input  logic [trtcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [trtcm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import trtcm_pkg::*;

   localparam int INC_BITS = BURST_BITS + FRAC_BITS + 1;

   logic [RATE_BITS-1:0]  committed_rate_ff, peak_rate_ff;
   logic [BURST_BITS-1:0] committed_burst_ff, peak_burst_ff;
   logic [BYTES_BITS-1:0] packet_bytes_ff;
   load_type              load;

   logic                  advance;
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic                  s2_adv_ff, s3_adv_ff, s4_adv_ff;
   logic [TIME_BITS-1:0]  now_ff, last_ff, elapsed_ff;
   logic                  time_adv;
   logic [INC_BITS-1:0]   inc_committed, inc_peak;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         committed_rate_ff  <= '0;
         peak_rate_ff       <= '0;
         committed_burst_ff <= '0;
         peak_burst_ff      <= '0;
         packet_bytes_ff    <= PACKET_BYTES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COMMITTED_RATE:  committed_rate_ff  <= csr_data[RATE_BITS-1:0];
            CSR_PEAK_RATE:       peak_rate_ff       <= csr_data[RATE_BITS-1:0];
            CSR_COMMITTED_BURST: committed_burst_ff <= csr_data[BURST_BITS-1:0];
            CSR_PEAK_BURST:      peak_burst_ff      <= csr_data[BURST_BITS-1:0];
            CSR_PACKET_BYTES:    packet_bytes_ff    <= csr_data[BYTES_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      load.committed = csr_write && (csr_index == CSR_COMMITTED_BURST);
      load.peak      = csr_write && (csr_index == CSR_PEAK_BURST);
      load.burst     = csr_data[BURST_BITS-1:0];
   end

   // whole pipeline moves unless a result word is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign time_adv  = now_ff > last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
         if (s1_valid_ff && time_adv) begin
            last_ff <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         now_ff     <= TIME_BITS'(req_arrival_time);
         elapsed_ff <= now_ff - last_ff;
         s2_adv_ff  <= time_adv;
         s3_adv_ff  <= s2_adv_ff;
         s4_adv_ff  <= s3_adv_ff;
      end
   end

   trtcm_scale #(
      .TIME_BITS (TIME_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_scale_committed (
      .clock     (clock),
      .enable    (advance),
      .elapsed   (elapsed_ff),
      .rate      (committed_rate_ff),
      .increment (inc_committed)
   );

   trtcm_scale #(
      .TIME_BITS (TIME_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_scale_peak (
      .clock     (clock),
      .enable    (advance),
      .elapsed   (elapsed_ff),
      .rate      (peak_rate_ff),
      .increment (inc_peak)
   );

   trtcm_marker #(
      .FRAC_BITS (FRAC_BITS)
   ) u_marker (
      .clock           (clock),
      .reset           (reset),
      .step            (advance && s4_valid_ff),
      .advanced        (s4_adv_ff),
      .inc_committed   (inc_committed),
      .inc_peak        (inc_peak),
      .committed_burst (committed_burst_ff),
      .peak_burst      (peak_burst_ff),
      .packet_bytes    (packet_bytes_ff),
      .load            (load),
      .color           (rsp_color)
   );

   assign rsp_valid = rsp_valid_ff;

   a_color_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_color == COLOR_GREEN || rsp_color == COLOR_YELLOW ||
                     rsp_color == COLOR_RED))
      else $error("result word carries an unused color code");

   a_zero_size_green: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && packet_bytes_ff == '0) |-> rsp_color == COLOR_GREEN)
      else $error("zero-size packet not marked green");

   a_no_peak_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && peak_burst_ff == '0 && packet_bytes_ff != '0) |->
      rsp_color == COLOR_RED)
      else $error("packet passed an empty peak bucket");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result word");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> last_ff >= $past(last_ff))
      else $error("last update time moved backward");

endmodule

// ===== tb/trtcm_color_checker.sv =====
module trtcm_color_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [trtcm_pkg::ARRIVAL_BITS-1:0]   req_arrival_time,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  trtcm_pkg::color_type                 rsp_color,
   input  logic                                 csr_write,
   input  logic [trtcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [trtcm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                   errors,
   output int                                   pending,
   output int                                   green_words,
   output int                                   yellow_words,
   output int                                   red_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import trtcm_pkg::*;

   // token fraction width equals the rate fraction width, so no rescale of the gain
   localparam int FRAC = FRAC_BITS_DEFAULT;

   logic [RATE_BITS-1:0]    committed_rate;
   logic [RATE_BITS-1:0]    peak_rate;
   logic [BURST_BITS-1:0]   committed_burst;
   logic [BURST_BITS-1:0]   peak_burst;
   logic [BYTES_BITS-1:0]   packet_size;
   logic [63:0]             committed_tokens;
   logic [63:0]             peak_tokens;
   logic [ARRIVAL_BITS-1:0] last_update;

   color_type expected_colors[$];

   initial begin
      errors       = 0;
      pending      = 0;
      green_words  = 0;
      yellow_words = 0;
      red_words    = 0;
   end

   function automatic logic [63:0] refill_bucket(input logic [63:0] tokens,
                                                 input logic [63:0] elapsed,
                                                 input logic [63:0] rate,
                                                 input logic [63:0] burst);
      logic [127:0] product;
      logic [63:0]  gain;
      logic [63:0]  cap;
      cap     = burst << FRAC;
      product = 128'(elapsed) * 128'(rate);
      // saturate the product at 64 bits
      gain    = (product[127:64] != 64'd0) ? {64{1'b1}} : product[63:0];
      if (tokens >= cap || gain >= cap - tokens) return cap;
      return tokens + gain;
   endfunction

   function automatic color_type mark_packet(input logic [ARRIVAL_BITS-1:0] now);
      logic [63:0] need;
      logic [63:0] elapsed;
      need = 64'(packet_size) << FRAC;
      if (now > last_update) begin
         elapsed          = 64'(now - last_update);
         committed_tokens = refill_bucket(committed_tokens, elapsed, 64'(committed_rate),
                                          64'(committed_burst));
         peak_tokens      = refill_bucket(peak_tokens, elapsed, 64'(peak_rate),
                                          64'(peak_burst));
         last_update      = now;
      end
      if (committed_tokens >= need && peak_tokens >= need) begin
         committed_tokens -= need;
         peak_tokens      -= need;
         return COLOR_GREEN;
      end else if (peak_tokens >= need) begin
         peak_tokens -= need;
         return COLOR_YELLOW;
      end
      return COLOR_RED;
   endfunction

   always @(posedge clock) begin : watch
      color_type want;
      if (reset) begin
         committed_rate   = '0;
         peak_rate        = '0;
         committed_burst  = '0;
         peak_burst       = '0;
         packet_size      = PACKET_BYTES_RESET;
         committed_tokens = '0;
         peak_tokens      = '0;
         last_update      = '0;
         expected_colors.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_COMMITTED_RATE: committed_rate = csr_data[RATE_BITS-1:0];
               CSR_PEAK_RATE:      peak_rate = csr_data[RATE_BITS-1:0];
               CSR_COMMITTED_BURST: begin
                  committed_burst  = csr_data[BURST_BITS-1:0];
                  committed_tokens = 64'(committed_burst) << FRAC;
               end
               CSR_PEAK_BURST: begin
                  peak_burst  = csr_data[BURST_BITS-1:0];
                  peak_tokens = 64'(peak_burst) << FRAC;
               end
               CSR_PACKET_BYTES:   packet_size = csr_data[BYTES_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               $display("%0t: color word %0d with no packet waiting", $time, rsp_color);
               errors++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_color !== want) begin
                  $display("%0t: color mismatch, expected %0d actual %0d",
                           $time, want, rsp_color);
                  errors++;
               end
               case (want)
                  COLOR_GREEN:  green_words++;
                  COLOR_YELLOW: yellow_words++;
                  default:      red_words++;
               endcase
            end
         end
         if (req_valid && !req_stall)
            expected_colors = {expected_colors, mark_packet(req_arrival_time)};
      end
      pending = expected_colors.size();
   end

endmodule

// ===== tb/two_rate_three_color_marker_core_test.sv =====
module two_rate_three_color_marker_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import trtcm_pkg::*;

   localparam logic [ARRIVAL_BITS-1:0] HALF_SPAN = 48'h8000_0000_0000;
   localparam logic [ARRIVAL_BITS-1:0] LAST_STAMP = {ARRIVAL_BITS{1'b1}};
   localparam logic [CSR_INDEX_BITS-1:0] TOP_INDEX = {CSR_INDEX_BITS{1'b1}};
   localparam int RANDOM_PHASES = 9;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ARRIVAL_BITS-1:0]   req_arrival_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   color_type                 rsp_color;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int errors;
   int pending;
   int green_words;
   int yellow_words;
   int red_words;

   logic                    quiet = 1'b0;
   int                      stall_left = 0;
   logic [ARRIVAL_BITS-1:0] stamp = '0;
   int                      arrivals_sent = 0;
   int                      settings_made = 0;

   always #2 clock = ~clock;

   two_rate_three_color_marker_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_arrival_time (req_arrival_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color        (rsp_color),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   trtcm_color_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_arrival_time (req_arrival_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color        (rsp_color),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .errors           (errors),
      .pending          (pending),
      .green_words      (green_words),
      .yellow_words     (yellow_words),
      .red_words        (red_words)
   );

   // receiver: alternate stall bursts of random length with open runs
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 40);
      end else if ($urandom_range(0, 1) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end
   end

   task automatic send_arrival(input logic [ARRIVAL_BITS-1:0] t);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_arrival_time <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      arrivals_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold the sender until every color word is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_write <= 1'b0;
      settings_made++;
   endtask

   task automatic set_buckets(input logic [31:0] cr, input logic [31:0] pr,
                              input logic [23:0] cb, input logic [23:0] pb,
                              input logic [15:0] pkt);
      write_reg(CSR_COMMITTED_RATE, cr);
      write_reg(CSR_PEAK_RATE, pr);
      write_reg(CSR_COMMITTED_BURST, {8'($urandom), cb});
      write_reg(CSR_PEAK_BURST, {8'($urandom), pb});
      write_reg(CSR_PACKET_BYTES, {16'($urandom), pkt});
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(CSR_PACKET_BYTES + 1, TOP_INDEX)), $urandom);
      close_writes();
   endtask

   task automatic random_phase(input int phase);
      logic [15:0] pkt;
      logic [23:0] cb;
      logic [23:0] pb;
      logic [63:0] cr;
      logic [63:0] pr;
      int          pick;
      pkt = 16'($urandom_range(64, 1500));
      if ($urandom_range(0, 7) == 0) pkt = 16'($urandom);
      cb = 24'(pkt * $urandom_range(1, 4) + $urandom_range(0, pkt));
      pb = 24'(cb + pkt * $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) pb = 24'(pkt * $urandom_range(1, 3));
      cr = ({48'd0, pkt} << RATE_FRAC) / $urandom_range(4, 40);
      pr = cr * $urandom_range(1, 4);
      if (pr > 64'hFFFF_FFFF) pr = 64'hFFFF_FFFF;
      if ($urandom_range(0, 5) == 0) cr = 64'($urandom);
      case (phase)
         0: begin
            cr = '0;
            pr = '0;
         end
         1: begin
            cr = 64'hFFFF_FFFF;
            pr = 64'hFFFF_FFFF;
         end
         default: ;
      endcase
      drain();
      set_buckets(cr[31:0], pr[31:0], cb, pb, pkt);
      repeat (70) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_arrival(stamp);
         end else if (pick < 12) begin
            // stale stamp: no refill, still marked
            send_arrival(stamp - ARRIVAL_BITS'($urandom_range(1, 50)));
         end else begin
            if (pick < 16) stamp = stamp + ARRIVAL_BITS'($urandom);
            else stamp = stamp + ARRIVAL_BITS'($urandom_range(1, 30));
            send_arrival(stamp);
         end
         if (!quiet) begin
            if ($urandom_range(0, 59) == 0) drain();
            else if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 17));
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("Timeout: color words still outstanding");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty buckets, every packet red
      send_arrival(48'd0);
      send_arrival(48'd3);

      drain();
      set_buckets(32'h0001_0000, 32'h0002_0000, 24'd2000, 24'd3000, 16'd1000);
      repeat (4) send_arrival(48'd3);
      send_arrival(48'd503);
      send_arrival(HALF_SPAN);
      send_arrival(HALF_SPAN - 48'd10);
      send_arrival(HALF_SPAN);

      // every register at its top, data bits above each register set
      drain();
      write_reg(CSR_INDEX_BITS'(CSR_PACKET_BYTES + 1), '1);
      write_reg(CSR_INDEX_BITS'(TOP_INDEX - 1), '1);
      write_reg(TOP_INDEX, '1);
      write_reg(CSR_COMMITTED_RATE, '1);
      write_reg(CSR_PEAK_RATE, '1);
      write_reg(CSR_COMMITTED_BURST, '1);
      write_reg(CSR_PEAK_BURST, '1);
      write_reg(CSR_PACKET_BYTES, '1);
      close_writes();
      stamp = HALF_SPAN + 48'h100_0000_0000;
      send_arrival(stamp);
      send_arrival(stamp);
      stamp = stamp + 48'd1;
      send_arrival(stamp);

      // zero packet size over empty buckets: always green
      drain();
      write_reg(CSR_COMMITTED_RATE, '0);
      write_reg(CSR_PEAK_RATE, '0);
      write_reg(CSR_COMMITTED_BURST, '0);
      write_reg(CSR_PEAK_BURST, '0);
      write_reg(CSR_PACKET_BYTES, '0);
      close_writes();
      send_arrival(stamp);
      stamp = stamp + 48'd1;
      send_arrival(stamp);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
         random_phase(phase);
      end

      // top of the time range, then wrapped stamps that refill nothing
      drain();
      set_buckets(32'h0010_0000, 32'h0020_0000, 24'd5000, 24'd9000, 16'd1500);
      send_arrival(LAST_STAMP);
      send_arrival(LAST_STAMP);
      send_arrival(48'd0);
      send_arrival(48'd5);
      send_arrival(LAST_STAMP);
      send_arrival(48'd1);
      send_arrival(48'd2);

      drain();
      repeat (10) @(negedge clock);
      $display("Ran %0d arrivals across %0d register settings, including stale and wrapped stamps",
               arrivals_sent, settings_made);
      $display("Checked colors: green %0d, yellow %0d, red %0d",
               green_words, yellow_words, red_words);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== two_rate_three_color_marker_core.f =====
rtl/core/trtcm_pkg.sv
rtl/core/trtcm_scale.sv
rtl/core/trtcm_marker.sv
rtl/core/two_rate_three_color_marker_core.sv
tb/trtcm_color_checker.sv
tb/two_rate_three_color_marker_core_test.sv
